[rtl/core/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bit store with rank and select
// Sizes of the store, action codes and the word-level helper functions.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned MaxBits     = 65536;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned SuperBits   = 512;
  localparam int unsigned NumWords    = MaxBits / WordBits;
  localparam int unsigned NumSuper    = MaxBits / SuperBits + 1;
  localparam int unsigned WordIdxW    = $clog2(NumWords);
  localparam int unsigned BitOffW     = $clog2(WordBits);
  localparam int unsigned SuperIdxW   = $clog2(NumSuper);
  localparam int unsigned SbOfPosW    = $clog2(MaxBits) - $clog2(SuperBits);
  localparam int unsigned WordsPerSbW = $clog2(SuperBits / WordBits);
  localparam int unsigned PosW        = $clog2(MaxBits);
  localparam int unsigned LenW        = PosW + 1;
  localparam int unsigned PopW        = BitOffW + 1;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxBits);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_SET      = 3'd1,
    ACT_FINALIZE = 3'd2,
    ACT_ACCESS   = 3'd3,
    ACT_RANK     = 3'd4,
    ACT_SELECT   = 3'd5
  } action_e;

  // Count the ones of one word.
  function automatic logic [PopW-1:0] pop_count(input word_t w);
    logic [PopW-1:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + PopW'(w[i]);
    end
    return n;
  endfunction

  // Offset of the lowest set bit; zero for an empty word.
  function automatic logic [BitOffW-1:0] low_one(input word_t w);
    logic [BitOffW-1:0] off;
    off = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) off = BitOffW'(i);
    end
    return off;
  endfunction

endpackage

[rtl/core/bitvector_rank_select.sv]
// ----------------------------------------------------------------------------
// bitvector_rank_select: bit store with access, rank and select queries
// Sequenced block around three memories, one popcount unit and one lowest-one scan unit.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command by raising start with action_i and operand_i while busy is
//   low; the beat is taken at that clock edge. Exactly one result beat follows,
//   shown on answer_o, bit_value_o and error_flag_o for one cycle while
//   valid_o is high. The receiver cannot stall, so the result is never held.
//   Steps from accept to the result strobe:
//     unknown action, out-of-range set/access, select error, rank at
//     length zero: result registered straight from the idle state
//     set, access: one read of the word memory; select: one read of the position memory
//     rank: a read and an accumulate pass per word walked, at most 8 words,
//     bound by the single word read port feeding the popcount unit
//     clear: one word cleared per cycle across the whole word store
//     finalize: per word a fetch, a load, one scan pass per set bit and a pass
//     that moves on, then a closing step, bound by the word fetch and the lowest-one scan
//     emitting one position per cycle
//   After reset the block runs a clearing pass over the whole word store with busy
//   high and no result beat. The length register is written through cfg_we_i and
//   cfg_wdata_i at any edge; write it only while the block is idle.
// ----------------------------------------------------------------------------
module bitvector_rank_select
  import brs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  logic [16:0]          operand_i,
  input  logic                 cfg_we_i,
  input  logic [16:0]          cfg_wdata_i,
  output logic                 valid_o,
  output logic [16:0]          answer_o,
  output logic                 bit_value_o,
  output logic                 error_flag_o
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_CLR      = 14'b00000000000010,
    ST_SET_RD   = 14'b00000000000100,
    ST_SET_WR   = 14'b00000000001000,
    ST_ACC_RD   = 14'b00000000010000,
    ST_ACC_OUT  = 14'b00000000100000,
    ST_RK_RD    = 14'b00000001000000,
    ST_RK_ACC   = 14'b00000010000000,
    ST_SEL_RD   = 14'b00000100000000,
    ST_SEL_OUT  = 14'b00001000000000,
    ST_FIN_RD   = 14'b00010000000000,
    ST_FIN_LOAD = 14'b00100000000000,
    ST_FIN_BITS = 14'b01000000000000,
    ST_FIN_END  = 14'b10000000000000
  } state_e;

  // Memories
  word_t                 bw_mem [NumWords];
  logic [LenW-1:0]       sc_mem [NumSuper];
  logic [PosW-1:0]       op_mem [MaxBits];

  word_t                 bw_rdata_q;
  logic [LenW-1:0]       sc_rdata_q;
  logic [PosW-1:0]       op_rdata_q;

  logic                  bw_we;
  word_t                 bw_wdata;
  logic                  sc_we;
  logic [SuperIdxW-1:0]  sc_waddr;
  logic [LenW-1:0]       sc_wdata;
  logic                  op_we;

  // Control state
  state_e                state_q, state_d;
  logic [WordIdxW-1:0]   idx_q, idx_d;
  logic [WordIdxW-1:0]   last_q, last_d;
  logic [SbOfPosW-1:0]   sb_q, sb_d;
  logic [BitOffW-1:0]    off_q, off_d;
  logic [PosW-1:0]       k_q, k_d;
  logic [LenW-1:0]       acc_q, acc_d;
  logic                  first_q, first_d;
  logic                  rep_q, rep_d;
  logic [LenW-1:0]       run_q, run_d;
  logic [LenW-1:0]       ones_q, ones_d;
  logic [16:0]           total_q;
  word_t                 w_q, w_d;

  logic                  valid_q, valid_d;
  logic [16:0]           answer_q, answer_d;
  logic                  bitv_q, bitv_d;
  logic                  err_q, err_d;

  // Combinational helpers
  logic [LenW-1:0]       len;
  logic [LenW-1:0]       pos_clamp;
  logic [LenW-1:0]       base;
  logic [LenW-1:0]       rem;
  word_t                 fin_word;
  word_t                 rk_word;
  logic [LenW-1:0]       rk_sum;
  logic [BitOffW-1:0]    low_off;

  assign len = (total_q > MaxLen) ? MaxLen : total_q;
  assign pos_clamp = (LenW'(operand_i) >= len) ? (len - LenW'(1)) : LenW'(operand_i);
  assign base = {1'b0, idx_q, {BitOffW{1'b0}}};
  assign rem  = len - base;
  assign low_off = low_one(w_q);

  // Trim the fetched word to the configured length.
  always_comb begin
    fin_word = bw_rdata_q;
    if (base >= len) begin
      fin_word = '0;
    end else if (rem < LenW'(WordBits)) begin
      fin_word = bw_rdata_q & ~({WordBits{1'b1}} << rem[BitOffW-1:0]);
    end
  end

  // Keep bits up to the rank position in the last word.
  always_comb begin
    rk_word = bw_rdata_q;
    if (idx_q == last_q) begin
      rk_word = bw_rdata_q & ({WordBits{1'b1}} >> (BitOffW'(WordBits - 1) - off_q));
    end
    rk_sum = (first_q ? sc_rdata_q : acc_q) + LenW'(pop_count(rk_word));
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    last_d   = last_q;
    sb_d     = sb_q;
    off_d    = off_q;
    k_d      = k_q;
    acc_d    = acc_q;
    first_d  = first_q;
    rep_d    = rep_q;
    run_d    = run_q;
    ones_d   = ones_q;
    w_d      = w_q;
    valid_d  = 1'b0;
    answer_d = answer_q;
    bitv_d   = bitv_q;
    err_d    = err_q;
    bw_we    = 1'b0;
    bw_wdata = '0;
    sc_we    = 1'b0;
    sc_waddr = '0;
    sc_wdata = '0;
    op_we    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          // Default result: all zero, shown next cycle unless a walk starts.
          answer_d = '0;
          bitv_d   = 1'b0;
          err_d    = 1'b0;
          case (action_i)
            ACT_CLEAR: begin
              idx_d   = '0;
              rep_d   = 1'b1;
              state_d = ST_CLR;
            end
            ACT_SET: begin
              if (LenW'(operand_i) < len) begin
                idx_d   = operand_i[PosW-1:BitOffW];
                off_d   = operand_i[BitOffW-1:0];
                state_d = ST_SET_RD;
              end else begin
                valid_d = 1'b1;
              end
            end
            ACT_FINALIZE: begin
              idx_d   = '0;
              run_d   = '0;
              state_d = ST_FIN_RD;
            end
            ACT_ACCESS: begin
              if (LenW'(operand_i) < len) begin
                idx_d   = operand_i[PosW-1:BitOffW];
                off_d   = operand_i[BitOffW-1:0];
                state_d = ST_ACC_RD;
              end else begin
                valid_d = 1'b1;
              end
            end
            ACT_RANK: begin
              if (len == '0) begin
                valid_d = 1'b1;
              end else begin
                sb_d    = pos_clamp[PosW-1:PosW-SbOfPosW];
                idx_d   = {pos_clamp[PosW-1:PosW-SbOfPosW], {WordsPerSbW{1'b0}}};
                last_d  = pos_clamp[PosW-1:BitOffW];
                off_d   = pos_clamp[BitOffW-1:0];
                first_d = 1'b1;
                state_d = ST_RK_RD;
              end
            end
            ACT_SELECT: begin
              if (operand_i == '0 || operand_i > ones_q) begin
                err_d   = 1'b1;
                valid_d = 1'b1;
              end else begin
                k_d     = PosW'(operand_i - 17'd1);
                state_d = ST_SEL_RD;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      // Sweep the word store and the superblock counts to zero.
      ST_CLR: begin
        bw_we    = 1'b1;
        bw_wdata = '0;
        if (WordIdxW'(idx_q) < WordIdxW'(NumSuper)) begin
          sc_we    = 1'b1;
          sc_waddr = SuperIdxW'(idx_q);
        end
        if (idx_q == WordIdxW'(NumWords - 1)) begin
          ones_d  = '0;
          valid_d = rep_q;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + WordIdxW'(1);
        end
      end

      ST_SET_RD: state_d = ST_SET_WR;

      ST_SET_WR: begin
        bw_we    = 1'b1;
        bw_wdata = bw_rdata_q | (word_t'(1) << off_q);
        valid_d  = 1'b1;
        state_d  = ST_IDLE;
      end

      ST_ACC_RD: state_d = ST_ACC_OUT;

      ST_ACC_OUT: begin
        bitv_d  = bw_rdata_q[off_q];
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end

      ST_RK_RD: state_d = ST_RK_ACC;

      // Add one word's popcount per pass; the first pass seeds from the count.
      ST_RK_ACC: begin
        first_d = 1'b0;
        acc_d   = rk_sum;
        if (idx_q == last_q) begin
          answer_d = rk_sum;
          valid_d  = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          idx_d   = idx_q + WordIdxW'(1);
          state_d = ST_RK_RD;
        end
      end

      ST_SEL_RD: state_d = ST_SEL_OUT;

      ST_SEL_OUT: begin
        answer_d = 17'(op_rdata_q);
        valid_d  = 1'b1;
        state_d  = ST_IDLE;
      end

      // Record the running count at each superblock boundary.
      ST_FIN_RD: begin
        if (idx_q[WordsPerSbW-1:0] == '0) begin
          sc_we    = 1'b1;
          sc_waddr = SuperIdxW'(idx_q[WordIdxW-1:WordsPerSbW]);
          sc_wdata = run_q;
        end
        state_d = ST_FIN_LOAD;
      end

      ST_FIN_LOAD: begin
        w_d     = fin_word;
        state_d = ST_FIN_BITS;
      end

      // Emit one set position per cycle, lowest first.
      ST_FIN_BITS: begin
        if (w_q != '0) begin
          op_we = 1'b1;
          run_d = run_q + LenW'(1);
          w_d   = w_q & (w_q - word_t'(1));
        end else if (idx_q == WordIdxW'(NumWords - 1)) begin
          state_d = ST_FIN_END;
        end else begin
          idx_d   = idx_q + WordIdxW'(1);
          state_d = ST_FIN_RD;
        end
      end

      ST_FIN_END: begin
        sc_we    = 1'b1;
        sc_waddr = SuperIdxW'(NumSuper - 1);
        sc_wdata = run_q;
        ones_d   = run_q;
        valid_d  = 1'b1;
        state_d  = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      idx_q   <= '0;
      rep_q   <= 1'b0;
      ones_q  <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
      first_q <= 1'b0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rep_q   <= rep_d;
      ones_q  <= ones_d;
      valid_q <= valid_d;
      first_q <= first_d;
      run_q   <= run_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    sb_q     <= sb_d;
    off_q    <= off_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    w_q      <= w_d;
    answer_q <= answer_d;
    bitv_q   <= bitv_d;
    err_q    <= err_d;
  end

  // Word store: one write, one registered read at the walk index.
  always_ff @(posedge clk_i) begin
    if (bw_we) begin
      bw_mem[idx_q] <= bw_wdata;
    end
    bw_rdata_q <= bw_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    sc_rdata_q <= sc_mem[SuperIdxW'(sb_q)];
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      op_mem[run_q[PosW-1:0]] <= PosW'(base) | PosW'(low_off);
    end
    op_rdata_q <= op_mem[k_q];
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign answer_o     = answer_q;
  assign bit_value_o  = bitv_q;
  assign error_flag_o = err_q;

endmodule

[rtl/core/brs_checker.sv]
// ----------------------------------------------------------------------------
// brs_assert: port-level checks of the bit store with rank and select
// Watches the command and result ports and flags inconsistent beats.
// ----------------------------------------------------------------------------
module brs_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [16:0] answer_o,
  input logic        bit_value_o,
  input logic        error_flag_o
);

  // An accepted beat either yields its result next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || valid_o))
    else $error("accepted command neither answered nor busy");

  a_err_no_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_flag_o) |-> (answer_o == 17'd0 && !bit_value_o))
    else $error("select error carries a payload");

  a_bit_no_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bit_value_o) |-> (answer_o == 17'd0))
    else $error("access result carries an answer");

endmodule

bind bitvector_rank_select brs_assert u_brs_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .answer_o     (answer_o),
  .bit_value_o  (bit_value_o),
  .error_flag_o (error_flag_o)
);
